/* src/shp_pkg.sv */
package shp_pkg;

	localparam int unsigned HdrBytes = 40;
	localparam int unsigned CntW = $clog2(HdrBytes);
	localparam logic [CntW-1:0] LastIdx = CntW'(HdrBytes - 1);

	// fixed header words folded into the sums
	localparam logic [15:0] IpFixed  = 16'h452E;  // 0x4500 + length 0x0028 + protocol 6
	localparam logic [15:0] TcpFixed = 16'h501C;  // 0x0006 + 0x0014 + offset and syn 0x5002
	localparam logic [7:0]  ProtoTcp = 8'h06;

	localparam int unsigned IndexW = 2;
	localparam int unsigned CfgDataW = 32;

	typedef enum logic [IndexW-1:0] {
		REG_SRC_ADDR = 2'd0,
		REG_DST_ADDR = 2'd1,
		REG_SRC_PORT = 2'd2,
		REG_DST_PORT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] target_address;
		logic [15:0] source_port;
		logic [15:0] target_port;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  hop_limit;
		logic [15:0] probe_ident;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} hdr_t;

	// header byte k in wire order
	function automatic logic [7:0] hdr_byte(input logic [CntW-1:0] k, input hdr_t h,
	                                        input cfg_t c);
		logic [7:0] b;
		b = 8'h00;
		case (k)
			6'd0:  b = 8'h45;
			6'd3:  b = 8'h28;
			6'd4:  b = h.probe_ident[15:8];
			6'd5:  b = h.probe_ident[7:0];
			6'd8:  b = h.hop_limit;
			6'd9:  b = ProtoTcp;
			6'd10: b = h.ip_csum[15:8];
			6'd11: b = h.ip_csum[7:0];
			6'd12: b = c.source_address[31:24];
			6'd13: b = c.source_address[23:16];
			6'd14: b = c.source_address[15:8];
			6'd15: b = c.source_address[7:0];
			6'd16: b = c.target_address[31:24];
			6'd17: b = c.target_address[23:16];
			6'd18: b = c.target_address[15:8];
			6'd19: b = c.target_address[7:0];
			6'd20: b = c.source_port[15:8];
			6'd21: b = c.source_port[7:0];
			6'd22: b = c.target_port[15:8];
			6'd23: b = c.target_port[7:0];
			6'd32: b = 8'h50;
			6'd33: b = 8'h02;
			6'd36: b = h.tcp_csum[15:8];
			6'd37: b = h.tcp_csum[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* src/shp_csum_pipe.sv */
module shp_csum_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_hop,
	input  logic [15:0]   in_ident,
	input  shp_pkg::cfg_t cfg,
	output logic          out_valid,
	input  logic          out_ready,
	output shp_pkg::hdr_t out_hdr
);
	import shp_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy1, rdy2, rdy3, rdy4;
	logic [7:0]  hop_s1, hop_s2, hop_s3, hop_s4;
	logic [15:0] id_s1, id_s2, id_s3, id_s4;
	logic [17:0] ipa_s1, addr_s1, tcpa_s1;
	logic [18:0] ips_s2, tcps_s2;
	logic [16:0] ipf_s3, tcpf_s3;
	logic [15:0] ipc_s4, tcpc_s4;
	logic [16:0] ipf2, tcpf2;

	// stall chain: a stage moves when it is empty or its successor moves
	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: partial word sums
	always_ff @(posedge clk) begin
		if (rdy1) begin
			hop_s1  <= in_hop;
			id_s1   <= in_ident;
			ipa_s1  <= 18'(IpFixed) + 18'(in_ident) + 18'({in_hop, 8'h00});
			addr_s1 <= 18'(cfg.source_address[31:16]) + 18'(cfg.source_address[15:0])
			         + 18'(cfg.target_address[31:16]) + 18'(cfg.target_address[15:0]);
			tcpa_s1 <= 18'(TcpFixed) + 18'(cfg.source_port) + 18'(cfg.target_port);
		end
	end

	// stage 2: full sums
	always_ff @(posedge clk) begin
		if (rdy2) begin
			hop_s2  <= hop_s1;
			id_s2   <= id_s1;
			ips_s2  <= 19'(ipa_s1) + 19'(addr_s1);
			tcps_s2 <= 19'(tcpa_s1) + 19'(addr_s1);
		end
	end

	// stage 3: first end-around carry fold
	always_ff @(posedge clk) begin
		if (rdy3) begin
			hop_s3  <= hop_s2;
			id_s3   <= id_s2;
			ipf_s3  <= 17'(ips_s2[15:0]) + 17'(ips_s2[18:16]);
			tcpf_s3 <= 17'(tcps_s2[15:0]) + 17'(tcps_s2[18:16]);
		end
	end

	// stage 4: last fold and complement
	assign ipf2  = 17'(ipf_s3[15:0]) + 17'(ipf_s3[16]);
	assign tcpf2 = 17'(tcpf_s3[15:0]) + 17'(tcpf_s3[16]);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			hop_s4  <= hop_s3;
			id_s4   <= id_s3;
			ipc_s4  <= ~ipf2[15:0];
			tcpc_s4 <= ~tcpf2[15:0];
		end
	end

	assign out_valid           = v_s4;
	assign out_hdr.hop_limit   = hop_s4;
	assign out_hdr.probe_ident = id_s4;
	assign out_hdr.ip_csum     = ipc_s4;
	assign out_hdr.tcp_csum    = tcpc_s4;

endmodule

/* src/shp_serializer.sv */
module shp_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  shp_pkg::hdr_t in_hdr,
	input  shp_pkg::cfg_t cfg,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import shp_pkg::*;

	hdr_t            hdr_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            is_last;
	logic            out_xfer;

	assign is_last  = (cnt_q == LastIdx);
	assign out_xfer = busy_q && out_ready;
	assign in_ready = !busy_q || (out_xfer && is_last);

	// byte counter and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_xfer) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	// held header fields
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hdr_q <= in_hdr;
		end
	end

	assign out_valid = busy_q;
	assign out_byte  = hdr_byte(cnt_q, hdr_q, cfg);
	assign out_last  = is_last;

endmodule

/* src/syn_probe_header_builder.sv */
// syn probe header builder
// input stream: one probe request per transaction, s_axis_tdata carries the
// hop limit and the identification value; each request yields a 40-byte
// ipv4 + tcp syn header on the byte-wide output stream, wire order, with
// m_axis_tlast on the fortieth byte.
// configuration: cfg_we / cfg_index / cfg_data write source address (0),
// target address (1), source port (2) and target port (3); write only while
// no request is in flight.
// path: a taken request passes the four checksum stages and the frame
// register before its first header byte is valid, then one byte per cycle
// while the receiver takes them.
// queueing: the byte-wide output sets the request rate; up to five
// requests queue in the checksum stages and the frame register, and the next
// frame follows the last byte with no gap.
// reset: all stages empty, addresses and source port 0, target port 80.
// stall: a low m_axis_tready holds the current byte; the stages fill and
// then s_axis_tready drops, nothing is lost or repeated.
module syn_probe_header_builder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // [7:0] hop_limit, [23:8] probe_ident
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [7:0] header_byte
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [shp_pkg::IndexW-1:0]    cfg_index,
	input  logic [shp_pkg::CfgDataW-1:0]  cfg_data
);
	import shp_pkg::*;

	cfg_t cfg_q;
	logic mid_valid;
	logic mid_ready;
	hdr_t mid_hdr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_address <= 32'd0;
			cfg_q.target_address <= 32'd0;
			cfg_q.source_port    <= 16'd0;
			cfg_q.target_port    <= 16'd80;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SRC_ADDR: cfg_q.source_address <= cfg_data;
				REG_DST_ADDR: cfg_q.target_address <= cfg_data;
				REG_SRC_PORT: cfg_q.source_port    <= cfg_data[15:0];
				REG_DST_PORT: cfg_q.target_port    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// checksum stages
	shp_csum_pipe u_csum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_hop    (s_axis_tdata[7:0]),
		.in_ident  (s_axis_tdata[23:8]),
		.cfg       (cfg_q),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_hdr   (mid_hdr)
	);

	// byte output
	shp_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_hdr    (mid_hdr),
		.cfg       (cfg_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* src/shp_checker.sv */
module shp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [7:0]                    m_axis_tdata,
	input logic                          m_axis_tlast
);

	// stalled output transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed under stall");

	// a frame runs without gaps once started
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a header frame");

	// a new frame begins with version and header length
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
			!m_axis_tvalid || m_axis_tdata == 8'h45)
		else $error("frame does not start with 0x45");

	// last byte is the zero urgent pointer low byte
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
		else $error("last header byte not zero");

	// with no frame on the output the input side is open
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while output idle");

endmodule

bind syn_probe_header_builder shp_checker u_chk (.*);
